[hdl/wpc_pkg.sv]
// ----------------------------------------------------------------------------
// wpc_pkg
// Shared types, sizes and helpers for the windowed profile counter bank.
// ----------------------------------------------------------------------------
package wpc_pkg;

   localparam int NUM_COUNTERS  = 32;
   localparam int WINDOW_SLICES = 61;
   localparam int SLICE_DEPTH   = NUM_COUNTERS * WINDOW_SLICES;

   localparam int SLICE_AW  = $clog2(SLICE_DEPTH);
   localparam int CNT_IDX_W = $clog2(NUM_COUNTERS);
   localparam int PTR_W     = $clog2(WINDOW_SLICES);
   localparam int USE_W     = 6;
   localparam int OP_W      = 2;
   localparam int TS_W      = 64;
   localparam int CNT_W     = 32;
   localparam int DEPTH_W   = 8;

   localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

   typedef enum logic [OP_W-1:0] {
      OP_PULSE = 2'd0,
      OP_ENTER = 2'd1,
      OP_EXIT  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RMW,
      ST_PULSE_RD,
      ST_PULSE_WR
   } state_type;

   typedef struct packed {
      logic [TS_W-1:0]  elapsed;
      logic [CNT_W-1:0] entries;
   } slice_word_type;

   typedef struct packed {
      logic [TS_W-1:0]    total_elapsed;
      logic [CNT_W-1:0]   total_entries;
      logic [DEPTH_W-1:0] depth;
   } total_word_type;

   typedef struct packed {
      logic                rd_en;
      logic [SLICE_AW-1:0] rd_addr_a;
      logic [SLICE_AW-1:0] rd_addr_b;
      logic                wr_en;
      logic [SLICE_AW-1:0] wr_addr;
      slice_word_type      wr_data;
   } slice_cmd_type;

   typedef struct packed {
      logic                 rd_en;
      logic [CNT_IDX_W-1:0] rd_addr;
      logic                 wr_en;
      logic [CNT_IDX_W-1:0] wr_addr;
      total_word_type       wr_data;
   } total_cmd_type;

   // flat slice address of one counter's slice in the ring
   function automatic logic [SLICE_AW-1:0] slice_addr(input logic [CNT_IDX_W-1:0] idx,
                                                      input logic [PTR_W-1:0] ptr);
      slice_addr = SLICE_AW'(idx) * SLICE_AW'(WINDOW_SLICES) + SLICE_AW'(ptr);
   endfunction

endpackage

[hdl/wpc_slice_mem.sv]
// ----------------------------------------------------------------------------
// wpc_slice_mem
// Slice store: one entry per counter and slice, two read ports, one write.
// ----------------------------------------------------------------------------
module wpc_slice_mem (
   input  logic                   clock,
   input  wpc_pkg::slice_cmd_type cmd,
   output wpc_pkg::slice_word_type rd_data_a,
   output wpc_pkg::slice_word_type rd_data_b
);
   import wpc_pkg::*;

   slice_word_type mem [SLICE_DEPTH];
   slice_word_type rd_a_ff;
   slice_word_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_a_ff <= mem[cmd.rd_addr_a];
         rd_b_ff <= mem[cmd.rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[hdl/wpc_total_mem.sv]
// ----------------------------------------------------------------------------
// wpc_total_mem
// Per-counter running totals and nesting depth, one read and one write port.
// ----------------------------------------------------------------------------
module wpc_total_mem (
   input  logic                    clock,
   input  wpc_pkg::total_cmd_type  cmd,
   output wpc_pkg::total_word_type rd_data
);
   import wpc_pkg::*;

   total_word_type mem [NUM_COUNTERS];
   total_word_type rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

[hdl/wpc_engine.sv]
// ----------------------------------------------------------------------------
// wpc_engine
// Sequencer and datapath: clearing sweep, enter/exit read-modify-write,
// pulse walk over the counters, shared slice pointer and response register.
// ----------------------------------------------------------------------------
module wpc_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [wpc_pkg::USE_W-1:0]      active,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [wpc_pkg::OP_W-1:0]       req_op,
   input  logic [wpc_pkg::CNT_IDX_W-1:0]  req_counter_index,
   input  logic [wpc_pkg::TS_W-1:0]       req_timestamp,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [wpc_pkg::TS_W-1:0]       rsp_window_time,
   output logic [wpc_pkg::CNT_W-1:0]      rsp_window_count,
   output logic [wpc_pkg::DEPTH_W-1:0]    rsp_nest_depth,
   output logic                           rsp_misuse_flag,
   output wpc_pkg::slice_cmd_type         slice_cmd,
   input  wpc_pkg::slice_word_type        slice_rd_a,
   input  wpc_pkg::slice_word_type        slice_rd_b,
   output wpc_pkg::total_cmd_type         total_cmd,
   input  wpc_pkg::total_word_type        total_rd
);
   import wpc_pkg::*;

   state_type             state_ff, state_in;
   logic [SLICE_AW-1:0]   clr_ff, clr_in;
   logic [CNT_IDX_W-1:0]  walk_ff, walk_in;
   logic [PTR_W-1:0]      ptr_ff, ptr_in;
   op_type                op_ff, op_in;
   logic [CNT_IDX_W-1:0]  idx_ff, idx_in;
   logic [TS_W-1:0]       ts_ff, ts_in;
   logic                  bad_ff, bad_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TS_W-1:0]       rsp_time_ff, rsp_time_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic [DEPTH_W-1:0]    rsp_depth_ff, rsp_depth_in;
   logic                  rsp_misuse_ff, rsp_misuse_in;

   op_type                req_op_w;
   logic                  accept;
   logic                  rsp_free;
   logic                  clr_last;
   logic                  walk_last;
   logic [PTR_W-1:0]      ptr_next;
   logic                  enter_ok;
   logic                  exit_ok;
   logic [DEPTH_W-1:0]    new_depth;
   slice_word_type        new_slice;
   total_word_type        new_total;

   assign req_op_w  = op_type'(req_op);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign clr_last  = (clr_ff == SLICE_AW'(SLICE_DEPTH - 1));
   assign walk_last = ((USE_W'(walk_ff) + USE_W'(1)) == active);
   assign ptr_next  = (ptr_ff == PTR_W'(WINDOW_SLICES - 1)) ? '0 : ptr_ff + PTR_W'(1);

   // read-modify-write of one slice and one counter
   always_comb begin
      enter_ok  = (op_ff == OP_ENTER) && (total_rd.depth != DEPTH_MAX);
      exit_ok   = (op_ff == OP_EXIT) && (total_rd.depth != '0);
      new_depth = total_rd.depth;
      new_slice = slice_rd_a;
      if (enter_ok) begin
         new_depth = total_rd.depth + DEPTH_W'(1);
         if (total_rd.depth == '0) begin
            new_slice.entries = slice_rd_a.entries + CNT_W'(1);
            new_slice.elapsed = slice_rd_a.elapsed - ts_ff;
         end
      end else if (exit_ok) begin
         new_depth = total_rd.depth - DEPTH_W'(1);
         if (total_rd.depth == DEPTH_W'(1)) begin
            new_slice.elapsed = slice_rd_a.elapsed + ts_ff;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op_w) inside
                  OP_ENTER, OP_EXIT: state_in = ST_RMW;
                  OP_PULSE: begin
                     if (active != '0) begin
                        state_in = ST_PULSE_RD;
                     end
                  end
                  OP_NOP: state_in = ST_IDLE;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_RMW: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_PULSE_RD: state_in = ST_PULSE_WR;
         ST_PULSE_WR: begin
            state_in = walk_last ? ST_IDLE : ST_PULSE_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and register updates
   always_comb begin
      clr_in        = clr_ff;
      walk_in       = walk_ff;
      ptr_in        = ptr_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      ts_in         = ts_ff;
      bad_in        = bad_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_time_in   = rsp_time_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_misuse_in = rsp_misuse_ff;

      new_total               = total_rd;
      new_total.total_elapsed = total_rd.total_elapsed + slice_rd_a.elapsed
                                - slice_rd_b.elapsed;
      new_total.total_entries = total_rd.total_entries + slice_rd_a.entries
                                - slice_rd_b.entries;

      slice_cmd           = '0;
      slice_cmd.rd_addr_a = slice_addr(idx_ff, ptr_ff);
      slice_cmd.rd_addr_b = slice_addr(walk_ff, ptr_next);
      slice_cmd.wr_addr   = slice_addr(idx_ff, ptr_ff);
      total_cmd           = '0;
      total_cmd.rd_addr   = idx_ff;
      total_cmd.wr_addr   = idx_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in            = clr_ff + SLICE_AW'(1);
            slice_cmd.wr_en   = 1'b1;
            slice_cmd.wr_addr = clr_ff;
            total_cmd.wr_en   = (clr_ff < SLICE_AW'(NUM_COUNTERS));
            total_cmd.wr_addr = clr_ff[CNT_IDX_W-1:0];
         end
         ST_IDLE: begin
            if (accept) begin
               op_in   = req_op_w;
               idx_in  = req_counter_index;
               ts_in   = req_timestamp;
               bad_in  = (USE_W'(req_counter_index) >= active);
               walk_in = '0;
               unique case (req_op_w) inside
                  OP_ENTER, OP_EXIT: begin
                     slice_cmd.rd_en     = 1'b1;
                     slice_cmd.rd_addr_a = slice_addr(req_counter_index, ptr_ff);
                     total_cmd.rd_en     = 1'b1;
                     total_cmd.rd_addr   = req_counter_index;
                  end
                  OP_PULSE: begin
                     // nothing to walk: the pointer still moves on
                     if (active == '0) begin
                        ptr_in = ptr_next;
                     end
                  end
                  OP_NOP: ;
                  default: ;
               endcase
            end
         end
         ST_RMW: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (bad_ff) begin
                  rsp_time_in   = '0;
                  rsp_count_in  = '0;
                  rsp_depth_in  = '0;
                  rsp_misuse_in = 1'b1;
               end else begin
                  rsp_time_in         = total_rd.total_elapsed;
                  rsp_count_in        = total_rd.total_entries;
                  rsp_depth_in        = new_depth;
                  rsp_misuse_in       = !(enter_ok || exit_ok);
                  slice_cmd.wr_en     = 1'b1;
                  slice_cmd.wr_data   = new_slice;
                  total_cmd.wr_en     = 1'b1;
                  total_cmd.wr_data   = total_rd;
                  total_cmd.wr_data.depth = new_depth;
               end
            end
         end
         ST_PULSE_RD: begin
            slice_cmd.rd_en     = 1'b1;
            slice_cmd.rd_addr_a = slice_addr(walk_ff, ptr_ff);
            total_cmd.rd_en     = 1'b1;
            total_cmd.rd_addr   = walk_ff;
         end
         ST_PULSE_WR: begin
            // fold current slice in, retire the oldest and clear it
            slice_cmd.wr_en   = 1'b1;
            slice_cmd.wr_addr = slice_addr(walk_ff, ptr_next);
            total_cmd.wr_en   = 1'b1;
            total_cmd.wr_addr = walk_ff;
            total_cmd.wr_data = new_total;
            if (walk_last) begin
               ptr_in = ptr_next;
            end else begin
               walk_in = walk_ff + CNT_IDX_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         walk_ff      <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         walk_ff      <= walk_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      ts_ff         <= ts_in;
      bad_ff        <= bad_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_misuse_ff <= rsp_misuse_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_window_time  = rsp_time_ff;
   assign rsp_window_count = rsp_count_ff;
   assign rsp_nest_depth   = rsp_depth_ff;
   assign rsp_misuse_flag  = rsp_misuse_ff;

   a_ptr_in_ring: assert property (@(posedge clock) disable iff (reset)
      ptr_ff < PTR_W'(WINDOW_SLICES))
      else $error("slice pointer left the ring");

   a_rsp_from_rmw: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RMW))
      else $error("response raised outside read-modify-write");

   a_zero_fill: assert property (@(posedge clock) disable iff (reset)
      slice_cmd.wr_en && (state_ff == ST_CLEAR || state_ff == ST_PULSE_WR)
      |-> slice_cmd.wr_data == '0)
      else $error("slice clear wrote non-zero data");

   a_ptr_moves: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && ptr_ff != $past(ptr_ff)
      |-> $past(state_ff == ST_IDLE || state_ff == ST_PULSE_WR))
      else $error("slice pointer moved outside a pulse");

endmodule

[hdl/windowed_profile_counters_core.sv]
// ----------------------------------------------------------------------------
// windowed_profile_counters_core
// Bank of profiling counters, each with a ring of time slices summed over a
// sliding window that a pulse request advances.
// ----------------------------------------------------------------------------
// After reset the block sweeps its slice store and counter table to zero, one
// entry per cycle, and takes no request until the sweep is done
// (counters_in_use writes are taken throughout). An enter or exit first
// reads the slice and counter entry, then writes them back and loads the
// response register; a no-op goes straight back to idle. A pulse walks the
// counters in use in turn on the slice store, first reading both slices and
// the totals, then writing the totals and clearing the oldest slice. Responses
// wait in an output register; a read-modify-write stalls only while that
// register is still full.
module windowed_profile_counters_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [wpc_pkg::USE_W-1:0]        csr_counters_in_use,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [wpc_pkg::OP_W-1:0]         req_op,
   input  logic [wpc_pkg::CNT_IDX_W-1:0]    req_counter_index,
   input  logic signed [wpc_pkg::TS_W-1:0]  req_timestamp,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [wpc_pkg::TS_W-1:0]  rsp_window_time,
   output logic [wpc_pkg::CNT_W-1:0]        rsp_window_count,
   output logic [wpc_pkg::DEPTH_W-1:0]      rsp_nest_depth,
   output logic                             rsp_misuse_flag
);
   import wpc_pkg::*;

   logic [USE_W-1:0] in_use_ff, in_use_in;
   logic [USE_W-1:0] active;
   slice_cmd_type    slice_cmd;
   slice_word_type   slice_rd_a;
   slice_word_type   slice_rd_b;
   total_cmd_type    total_cmd;
   total_word_type   total_rd;

   assign csr_ready = 1'b1;
   assign in_use_in = (csr_valid && csr_ready) ? csr_counters_in_use : in_use_ff;

   // values above the bank size act as the bank size
   assign active = (in_use_ff > USE_W'(NUM_COUNTERS)) ? USE_W'(NUM_COUNTERS) : in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= USE_W'(NUM_COUNTERS);
      end else begin
         in_use_ff <= in_use_in;
      end
   end

   wpc_slice_mem u_slice_mem (
      .clock     (clock),
      .cmd       (slice_cmd),
      .rd_data_a (slice_rd_a),
      .rd_data_b (slice_rd_b)
   );

   wpc_total_mem u_total_mem (
      .clock   (clock),
      .cmd     (total_cmd),
      .rd_data (total_rd)
   );

   wpc_engine u_engine (
      .clock             (clock),
      .reset             (reset),
      .active            (active),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_counter_index (req_counter_index),
      .req_timestamp     (req_timestamp),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_window_time   (rsp_window_time),
      .rsp_window_count  (rsp_window_count),
      .rsp_nest_depth    (rsp_nest_depth),
      .rsp_misuse_flag   (rsp_misuse_flag),
      .slice_cmd         (slice_cmd),
      .slice_rd_a        (slice_rd_a),
      .slice_rd_b        (slice_rd_b),
      .total_cmd         (total_cmd),
      .total_rd          (total_rd)
   );

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for windowed_profile_counters_core. Enter, exit and pulse
// requests are mirrored in an untimed copy of the counter bank. Both sides idle
// at random; each response is compared with the copy's or a typed row's reading.
// ----------------------------------------------------------------------------
module tb;
   import wpc_pkg::*;

   localparam int SETTLE_CYCLES   = 100;
   localparam int RSP_HOLD_CYCLES = 400;

   typedef struct packed {
      logic [TS_W-1:0]    window_time;
      logic [CNT_W-1:0]   window_count;
      logic [DEPTH_W-1:0] nest_depth;
      logic               misuse_flag;
   } counter_reading_type;

   typedef struct packed {
      op_type               op;
      logic [CNT_IDX_W-1:0] counter_index;
      logic [TS_W-1:0]      timestamp;
      logic                 typed;
      counter_reading_type  reading;
   } directed_row_type;

   localparam counter_reading_type MODEL_READING = '0;
   localparam counter_reading_type EMPTY_MISUSE  = '{64'd0, 32'd0, 8'd0, 1'b1};
   localparam counter_reading_type FIRST_ENTRY   = '{64'd0, 32'd0, 8'd1, 1'b0};

   // run with counters_in_use at 20, so indexes 20 and up are out of range
   localparam directed_row_type DIRECTED_ROWS [20] = '{
      '{OP_EXIT,  5'd0,  64'd7,                  1'b1, EMPTY_MISUSE},
      '{OP_ENTER, 5'd0,  64'd100,                1'b1, FIRST_ENTRY},
      '{OP_ENTER, 5'd0,  64'd200,                1'b0, MODEL_READING},
      '{OP_EXIT,  5'd0,  64'd250,                1'b0, MODEL_READING},
      '{OP_EXIT,  5'd0,  64'd400,                1'b0, MODEL_READING},
      '{OP_ENTER, 5'd31, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, EMPTY_MISUSE},
      '{OP_EXIT,  5'd20, 64'h8000_0000_0000_0000, 1'b1, EMPTY_MISUSE},
      '{OP_PULSE, 5'd31, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, MODEL_READING},
      '{OP_NOP,   5'd31, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, MODEL_READING},
      '{OP_ENTER, 5'd0,  64'd1000,               1'b0, MODEL_READING},
      '{OP_EXIT,  5'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, MODEL_READING},
      '{OP_ENTER, 5'd19, 64'h8000_0000_0000_0000, 1'b0, MODEL_READING},
      '{OP_EXIT,  5'd19, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, MODEL_READING},
      '{OP_ENTER, 5'd10, 64'h5555_5555_5555_5555, 1'b0, MODEL_READING},
      '{OP_ENTER, 5'd10, 64'd0,                  1'b0, MODEL_READING},
      '{OP_EXIT,  5'd10, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, MODEL_READING},
      '{OP_EXIT,  5'd10, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, MODEL_READING},
      '{OP_PULSE, 5'd0,  64'd0,                  1'b0, MODEL_READING},
      '{OP_EXIT,  5'd10, 64'd3,                  1'b0, MODEL_READING},
      '{OP_ENTER, 5'd21, 64'd0,                  1'b1, EMPTY_MISUSE}
   };

   logic                  clock;
   logic                  reset;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [USE_W-1:0]      csr_counters_in_use;
   logic                  req_valid;
   logic                  req_ready;
   logic [OP_W-1:0]       req_op;
   logic [CNT_IDX_W-1:0]  req_counter_index;
   logic signed [TS_W-1:0] req_timestamp;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic signed [TS_W-1:0] rsp_window_time;
   logic [CNT_W-1:0]      rsp_window_count;
   logic [DEPTH_W-1:0]    rsp_nest_depth;
   logic                  rsp_misuse_flag;

   windowed_profile_counters_core uut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_counters_in_use (csr_counters_in_use),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_counter_index   (req_counter_index),
      .req_timestamp       (req_timestamp),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_window_time     (rsp_window_time),
      .rsp_window_count    (rsp_window_count),
      .rsp_nest_depth      (rsp_nest_depth),
      .rsp_misuse_flag     (rsp_misuse_flag)
   );

   // untimed copy of the counter bank
   bit [TS_W-1:0]    slice_time_m  [NUM_COUNTERS][WINDOW_SLICES];
   bit [CNT_W-1:0]   slice_count_m [NUM_COUNTERS][WINDOW_SLICES];
   bit [TS_W-1:0]    total_time_m  [NUM_COUNTERS];
   bit [CNT_W-1:0]   total_count_m [NUM_COUNTERS];
   bit [DEPTH_W-1:0] depth_m       [NUM_COUNTERS];
   int               slice_ptr_m;
   int               counters_in_use_m = NUM_COUNTERS;

   counter_reading_type pending_readings [$];
   int               mismatch_count;
   bit               smooth_flow;
   bit               hold_off_rsp;
   logic [TS_W-1:0]  machine_clock;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      #(12_000_000);
      $display("FAILURE");
      $finish;
   end

   function automatic int live_counters();
      return (counters_in_use_m > NUM_COUNTERS) ? NUM_COUNTERS : counters_in_use_m;
   endfunction

   // applies one request to the bank copy; returns 1 when a response follows
   function automatic bit bank_model_step(input op_type op, input int idx,
                                          input logic [TS_W-1:0] ts,
                                          output counter_reading_type reading);
      int nxt;
      reading = '0;
      case (op)
         OP_PULSE: begin
            nxt = (slice_ptr_m + 1) % WINDOW_SLICES;
            for (int c = 0; c < live_counters(); c++) begin
               total_time_m[c]  += slice_time_m[c][slice_ptr_m] - slice_time_m[c][nxt];
               total_count_m[c] += slice_count_m[c][slice_ptr_m] - slice_count_m[c][nxt];
               slice_time_m[c][nxt]  = '0;
               slice_count_m[c][nxt] = '0;
            end
            slice_ptr_m = nxt;
            return 1'b0;
         end
         OP_NOP: return 1'b0;
         default: ;
      endcase
      if (idx >= live_counters()) begin
         reading.misuse_flag = 1'b1;
         return 1'b1;
      end
      if (op == OP_ENTER) begin
         if (depth_m[idx] >= DEPTH_MAX) begin
            reading.misuse_flag = 1'b1;
         end else begin
            // only the outermost enter counts and opens the interval
            if (depth_m[idx] == 0) begin
               slice_count_m[idx][slice_ptr_m] += 1;
               slice_time_m[idx][slice_ptr_m]  -= ts;
            end
            depth_m[idx] += 1;
         end
      end else if (depth_m[idx] == 0) begin
         reading.misuse_flag = 1'b1;
      end else begin
         depth_m[idx] -= 1;
         if (depth_m[idx] == 0)
            slice_time_m[idx][slice_ptr_m] += ts;
      end
      reading.window_time  = total_time_m[idx];
      reading.window_count = total_count_m[idx];
      reading.nest_depth   = depth_m[idx];
      return 1'b1;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_idle(input int long_lo, input int long_hi);
      int r;
      if (smooth_flow)
         return 0;
      r = $urandom_range(99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(3, 1);
      return $urandom_range(long_hi, long_lo);
   endfunction

   function automatic void check_field(input string field, input logic [TS_W-1:0] want,
                                       input logic [TS_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic offer_request(input op_type op, input int idx, input logic [TS_W-1:0] ts,
                                input bit typed = 1'b0,
                                input counter_reading_type typed_reading = '0);
      counter_reading_type reading;
      int gap;
      req_valid         <= 1'b1;
      req_op            <= op;
      req_counter_index <= CNT_IDX_W'(idx);
      req_timestamp     <= ts;
      do @(posedge clock); while (!req_ready);
      if (bank_model_step(op, idx, ts, reading))
         pending_readings.push_back(typed ? typed_reading : reading);
      gap = pick_idle(8, 40);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic offer_random_request();
      int live;
      int r;
      int idx;
      op_type op;
      logic [TS_W-1:0] ts;
      live = live_counters();
      r    = $urandom_range(99);
      idx  = $urandom_range(NUM_COUNTERS - 1);
      machine_clock += $urandom_range(5000, 1);
      ts = ($urandom_range(9) == 0) ? {$urandom, $urandom} : machine_clock;
      if (r < 12)
         op = OP_PULSE;
      else if (r < 15)
         op = OP_NOP;
      else if (r < 22 || live == 0)
         op = $urandom_range(1) ? OP_ENTER : OP_EXIT;
      else begin
         // well-formed nesting on a live counter, leaning on the first few
         idx = $urandom_range(1) ? $urandom_range(((live < 4) ? live : 4) - 1)
                                 : $urandom_range(live - 1);
         if (depth_m[idx] == 0)
            op = ($urandom_range(19) == 0) ? OP_EXIT : OP_ENTER;
         else if (depth_m[idx] > 3)
            op = ($urandom_range(3) == 0) ? OP_ENTER : OP_EXIT;
         else
            op = $urandom_range(1) ? OP_ENTER : OP_EXIT;
      end
      offer_request(op, idx, ts);
   endtask

   // only written with the bank idle: drained, then time for a full pulse walk
   task automatic write_counters_in_use(input logic [USE_W-1:0] in_use);
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid           <= 1'b1;
      csr_counters_in_use <= in_use;
      do @(posedge clock); while (!csr_ready);
      csr_valid         <= 1'b0;
      counters_in_use_m  = in_use;
   endtask

   task automatic run_phase(input logic [USE_W-1:0] in_use, input int count,
                            input bit steady, input bit hold_rsp);
      write_counters_in_use(in_use);
      smooth_flow  = steady;
      hold_off_rsp = hold_rsp;
      repeat (count) offer_random_request();
      req_valid   <= 1'b0;
      smooth_flow  = 1'b0;
   endtask

   initial begin : rsp_sink
      int stall_left;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_rsp) begin
            // long hold-off so the response register fills and requests back up
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            hold_off_rsp = 1'b0;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready  <= 1'b1;
            stall_left  = pick_idle(15, 60);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      counter_reading_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readings.size() == 0) begin
            $error("response with no request pending: time %0h count %0h depth %0d misuse %0b",
                   rsp_window_time, rsp_window_count, rsp_nest_depth, rsp_misuse_flag);
            mismatch_count++;
         end else begin
            want = pending_readings.pop_front();
            check_field("window_time", want.window_time, rsp_window_time);
            check_field("window_count", TS_W'(want.window_count), TS_W'(rsp_window_count));
            check_field("nest_depth", TS_W'(want.nest_depth), TS_W'(rsp_nest_depth));
            check_field("misuse_flag", TS_W'(want.misuse_flag), TS_W'(rsp_misuse_flag));
         end
      end
   end

   initial begin : stimulus
      reset               <= 1'b1;
      csr_valid           <= 1'b0;
      csr_counters_in_use <= '0;
      req_valid           <= 1'b0;
      req_op              <= OP_NOP;
      req_counter_index   <= '0;
      req_timestamp       <= '0;
      machine_clock        = {$urandom, $urandom};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      write_counters_in_use(6'd20);
      for (int i = 0; i < $size(DIRECTED_ROWS); i++)
         offer_request(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].counter_index,
                       DIRECTED_ROWS[i].timestamp, DIRECTED_ROWS[i].typed,
                       DIRECTED_ROWS[i].reading);
      req_valid <= 1'b0;

      run_phase(6'd63, 60, 1'b0, 1'b0);

      // nest one counter up to the depth limit and past it, then unwind past zero
      smooth_flow = 1'b1;
      for (int i = 0; i <= int'(DEPTH_MAX); i++) begin
         machine_clock += 13;
         offer_request(OP_ENTER, 7, machine_clock);
      end
      for (int i = 0; i <= int'(DEPTH_MAX); i++) begin
         machine_clock += 11;
         offer_request(OP_EXIT, 7, machine_clock);
      end
      smooth_flow = 1'b0;
      req_valid  <= 1'b0;

      run_phase(6'd1, 20, 1'b1, 1'b0);
      run_phase(6'd0, 20, 1'b0, 1'b0);
      run_phase(6'd45, 50, 1'b0, 1'b1);
      run_phase(USE_W'($urandom_range(31, 2)), 40, 1'b0, 1'b0);
      run_phase(6'd32, 40, 1'b0, 1'b0);

      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

[filelist.f]
hdl/wpc_pkg.sv
hdl/wpc_slice_mem.sv
hdl/wpc_total_mem.sv
hdl/wpc_engine.sv
hdl/windowed_profile_counters_core.sv
test/tb.sv
